/* rtl/hgbl_pkg.sv */
// Shared constants and types for the height grid bilinear lookup core.
package hgbl_pkg;

    localparam int GRID_MAX   = 256;
    localparam int IDX_W      = $clog2(GRID_MAX);
    localparam int SIZE_W     = IDX_W + 1;
    localparam int FRAC_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int HEIGHT_W   = 24;
    localparam int POS_W      = SIZE_W + FRAC_W;
    localparam int BANK_DEPTH = GRID_MAX * GRID_MAX / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int LERP_W     = SAMPLE_W + FRAC_W + 2;
    localparam int MIX_W      = LERP_W + FRAC_W + 1;
    localparam int OUT_LSB    = 2 * FRAC_W - 8;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 1;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(GRID_MAX);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD0  = 6'b000010,
        S_RD1  = 6'b000100,
        S_ROW1 = 6'b001000,
        S_MIX  = 6'b010000,
        S_SUM  = 6'b100000
    } t_state;

endpackage

/* rtl/height_grid_bilinear_lookup_core.sv */
// Height grid store with bilinear lookup, two column-parity RAM banks.
// Load transfer: written to the bank at the accept edge.
// Query transfer: no new transfer until back in IDLE; RD0, RD1, ROW1, MIX, SUM follow accept,
//   result registered in SUM, held on output stall; one read per row, shared lerp multiplier.
// Reset: row_size 256, write counters and output valid cleared; grid contents are not cleared.
module height_grid_bilinear_lookup_core
    import hgbl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // sample[15:0], lat_frac[31:16], lon_frac[47:32]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,  // op[0], first_sample[1]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // height[23:0]
    output logic [OUT_USER_W-1:0] m_axis_tuser,  // grid_complete[0]
    input  logic                  i_cfg_we,
    input  logic [SIZE_W-1:0]     i_cfg_wdata
);

    t_state r_state, n_state;

    logic [SIZE_W-1:0] r_rs, n_rs;
    logic [SIZE_W-1:0] r_row, n_row;
    logic [IDX_W-1:0]  r_col, n_col;

    logic [POS_W-1:0]  r_lat_pos, r_lon_pos;
    logic [IDX_W-1:0]  r_r1;
    logic [BANK_AW-IDX_W-1:0] r_c0addr, r_c1addr;
    logic              r_par;
    logic signed [LERP_W-1:0] r_row0, r_row1;
    logic signed [MIX_W-1:0]  r_prod;

    logic                r_out_valid;
    logic [HEIGHT_W-1:0] r_out_height;
    logic                r_out_complete;

    logic in_xfer, load_xfer, query_xfer;
    logic [SAMPLE_W-1:0] in_sample;
    logic [FRAC_W-1:0]   in_lat, in_lon;
    logic                in_first;

    logic [SIZE_W-1:0] row_eff;
    logic [IDX_W-1:0]  col_eff;
    logic              wr_en;
    logic              we0, we1;
    logic [BANK_AW-1:0] waddr;

    logic [SIZE_W-1:0] lat_i, lon_i, lat_c, lon_c, r0_full, lon_p1;
    logic [IDX_W-1:0]  r0;
    logic [BANK_AW-IDX_W-1:0] c0addr, c1addr;
    logic              rd_en;
    logic [BANK_AW-1:0] raddr0, raddr1;
    logic [SAMPLE_W-1:0] q0, q1;

    logic signed [SAMPLE_W-1:0] s_a, s_b;
    logic signed [SAMPLE_W:0]   ab_diff;
    logic signed [FRAC_W:0]     tz_s, tx_s;
    logic signed [LERP_W-1:0]   lerp;
    logic signed [LERP_W-1:0]   rows_diff;
    logic signed [MIX_W-1:0]    mix_prod;
    logic signed [MIX_W-1:0]    mix_sum;
    logic                       out_load;
    logic [SIZE_W-1:0]          cfg_rs;

    assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
    assign in_lat    = s_axis_tdata[SAMPLE_W+FRAC_W-1:SAMPLE_W];
    assign in_lon    = s_axis_tdata[SAMPLE_W+2*FRAC_W-1:SAMPLE_W+FRAC_W];
    assign in_first  = s_axis_tuser[1];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign load_xfer  = in_xfer && (s_axis_tuser[0] == OP_LOAD);
    assign query_xfer = in_xfer && (s_axis_tuser[0] == OP_QUERY);

    // load write path
    assign row_eff = in_first ? '0 : r_row;
    assign col_eff = in_first ? '0 : r_col;
    assign wr_en   = load_xfer && (row_eff < r_rs);
    assign we0     = wr_en && !col_eff[0];
    assign we1     = wr_en && col_eff[0];
    assign waddr   = {row_eff[IDX_W-1:0], col_eff[IDX_W-1:1]};

    always_comb begin
        if (i_cfg_wdata < SIZE_MIN) begin
            cfg_rs = SIZE_MIN;
        end else if (i_cfg_wdata > SIZE_MAX) begin
            cfg_rs = SIZE_MAX;
        end else begin
            cfg_rs = i_cfg_wdata;
        end
    end

    always_comb begin
        n_rs  = r_rs;
        n_row = r_row;
        n_col = r_col;
        if (i_cfg_we) begin
            n_rs  = cfg_rs;
            n_row = '0;
            n_col = '0;
        end else if (load_xfer) begin
            n_row = row_eff;
            n_col = col_eff;
            if (wr_en) begin
                if ({1'b0, col_eff} == r_rs - SIZE_W'(1)) begin
                    n_col = '0;
                    n_row = row_eff + SIZE_W'(1);
                end else begin
                    n_col = col_eff + IDX_W'(1);
                end
            end
        end
    end

    // index clamp and read addressing
    assign lat_i = r_lat_pos[POS_W-1:FRAC_W];
    assign lon_i = r_lon_pos[POS_W-1:FRAC_W];

    always_comb begin
        lat_c = lat_i;
        if (lat_i > r_rs - SIZE_W'(1)) begin
            lat_c = r_rs - SIZE_W'(1);
        end
        if (lat_c < SIZE_W'(1)) begin
            lat_c = SIZE_W'(1);
        end
        lon_c = lon_i;
        if (lon_i > r_rs - SIZE_W'(2)) begin
            lon_c = r_rs - SIZE_W'(2);
        end
    end

    assign r0_full = r_rs - lat_c;
    assign r0      = r0_full[IDX_W-1:0];
    assign lon_p1  = lon_c + SIZE_W'(1);
    assign c0addr  = lon_p1[IDX_W-1:1];
    assign c1addr  = lon_c[IDX_W-1:1];

    assign rd_en  = (r_state == S_RD0) || (r_state == S_RD1);
    assign raddr0 = (r_state == S_RD0) ? {r0, c0addr} : {r_r1, r_c0addr};
    assign raddr1 = (r_state == S_RD0) ? {r0, c1addr} : {r_r1, r_c1addr};

    hgbl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr),
        .i_wdata (in_sample),
        .i_re    (rd_en),
        .i_raddr (raddr0),
        .o_rdata (q0)
    );

    hgbl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BANK_DEPTH)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr),
        .i_wdata (in_sample),
        .i_re    (rd_en),
        .i_raddr (raddr1),
        .o_rdata (q1)
    );

    // shared row lerp: a*(2^16-tz) + b*tz = a*2^16 + (b-a)*tz
    assign s_a     = r_par ? q1 : q0;
    assign s_b     = r_par ? q0 : q1;
    assign ab_diff = {s_b[SAMPLE_W-1], s_b} - {s_a[SAMPLE_W-1], s_a};
    assign tz_s    = {1'b0, r_lon_pos[FRAC_W-1:0]};
    assign tx_s    = {1'b0, r_lat_pos[FRAC_W-1:0]};
    assign lerp    = $signed({{2{s_a[SAMPLE_W-1]}}, s_a, {FRAC_W{1'b0}}}) + ab_diff * tz_s;

    assign rows_diff = r_row1 - r_row0;
    assign mix_prod  = rows_diff * tx_s;
    assign mix_sum   = {r_row0[LERP_W-1], r_row0, {FRAC_W{1'b0}}} + r_prod;

    assign out_load = (r_state == S_SUM) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (query_xfer) begin
                    n_state = S_RD0;
                end
            end
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_ROW1;
            S_ROW1: n_state = S_MIX;
            S_MIX:  n_state = S_SUM;
            S_SUM: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rs        <= SIZE_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rs    <= n_rs;
            r_row   <= n_row;
            r_col   <= n_col;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (query_xfer) begin
            r_lat_pos <= POS_W'(r_rs * in_lat);
            r_lon_pos <= POS_W'(r_rs * in_lon);
        end
        if (r_state == S_RD0) begin
            r_r1     <= r0 - IDX_W'(1);
            r_c0addr <= c0addr;
            r_c1addr <= c1addr;
            r_par    <= lon_c[0];
        end
        if (r_state == S_RD1) begin
            r_row0 <= lerp;
        end
        if (r_state == S_ROW1) begin
            r_row1 <= lerp;
        end
        if (r_state == S_MIX) begin
            r_prod <= mix_prod;
        end
        if (out_load) begin
            r_out_height   <= mix_sum[OUT_LSB+HEIGHT_W-1:OUT_LSB];
            r_out_complete <= (r_row == r_rs);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_height;
    assign m_axis_tuser  = r_out_complete;

endmodule

/* rtl/hgbl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hgbl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
